/* rtl/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg
// shared types and constants of the three-phase sine/triangle pwm block
// ----------------------------------------------------------------------------
package spwm_pkg;

  // field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned CFREQ_W = 17;
  localparam int unsigned AMP_W   = 15;
  localparam int unsigned MODE_W  = 6;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP = 2'd0,
    REG_FREQ_GAIN  = 2'd1,
    REG_MIN_SPEED  = 2'd2,
    REG_ASYNC_FREQ = 2'd3
  } cfg_reg_e;

  localparam logic [STEP_W-1:0]  RST_PHASE_STEP = 32'd42950;
  localparam logic [GAIN_W-1:0]  RST_FREQ_GAIN  = 16'd13357;
  localparam logic [SPEED_W-1:0] RST_MIN_SPEED  = 16'd128;
  localparam logic [CFREQ_W-1:0] RST_ASYNC_FREQ = 17'd51200;

  // multiplier operand width on the serial side
  localparam int unsigned MUL_B_W = 17;

  // pulse modes (carrier pulses per sine cycle)
  localparam logic [MODE_W-1:0] MODE_ASYNC = 6'd0;
  localparam logic [MODE_W-1:0] MODE_1     = 6'd1;
  localparam logic [MODE_W-1:0] MODE_3     = 6'd3;
  localparam logic [MODE_W-1:0] MODE_9     = 6'd9;
  localparam logic [MODE_W-1:0] MODE_15    = 6'd15;
  localparam logic [MODE_W-1:0] MODE_27    = 6'd27;
  localparam logic [MODE_W-1:0] MODE_45    = 6'd45;
  localparam logic [MODE_W-1:0] MODE_1_CARRIER_MULT = 6'd3;

  // freq > k/10 Hz in q8.8  <=>  fs > floor(k*256/10)
  localparam logic [FREQ_W-1:0] THR_MODE_1  = 16'((443 * 256) / 10);
  localparam logic [FREQ_W-1:0] THR_MODE_3  = 16'((380 * 256) / 10);
  localparam logic [FREQ_W-1:0] THR_MODE_9  = 16'((250 * 256) / 10);
  localparam logic [FREQ_W-1:0] THR_MODE_15 = 16'((137 * 256) / 10);
  localparam logic [FREQ_W-1:0] THR_MODE_27 = 16'((70 * 256) / 10);
  localparam logic [FREQ_W-1:0] THR_MODE_45 = 16'((54 * 256) / 10);

  localparam logic [CFREQ_W-1:0] CFREQ_MAX = 17'h1FFFF;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = 16'hFFFF;

  // amplitude = fs*16/45 + 0.1 in q1.14
  localparam int unsigned AMP_DIVISOR = 45;
  localparam int unsigned AMP_DIV_W   = 20;
  localparam int unsigned AMP_OFFSET  = 1638;
  localparam int unsigned AMP_MAX     = 32767;

  // quarter-wave sine polynomial, q14
  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [14:0] SIN_C0  = 15'd1306;
  localparam logic [14:0] SIN_C1  = 15'd10583;
  localparam logic [14:0] SIN_C2  = 15'd25736;

  // triangle breakpoints on the top 16 carrier phase bits
  localparam logic [15:0] TRI_Q1 = 16'd16384;
  localparam logic [15:0] TRI_Q3 = 16'd49152;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

/* rtl/spwm_smul.sv */
// ----------------------------------------------------------------------------
// spwm_smul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module spwm_smul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [A_W-1:0]          a_i,
  input  logic [B_W-1:0]          b_i,
  output logic [A_W+B_W-1:0]      product_o,
  output spwm_pkg::unit_status_t  status_o
);
  import spwm_pkg::*;

  localparam int unsigned CW = $clog2(B_W + 1);

  logic [A_W-1:0] a_q;
  logic [A_W-1:0] hi_q;
  logic [B_W-1:0] lo_q;
  logic [CW-1:0]  cnt_q;
  logic           done_q;
  logic [A_W:0]   sum_w;

  // partial sum of the high half, low bit drops into the multiplier shifter
  assign sum_w = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q   <= a_i;
        hi_q  <= '0;
        lo_q  <= b_i;
        cnt_q <= CW'(B_W);
      end else if (cnt_q != '0) begin
        hi_q   <= sum_w[A_W:1];
        lo_q   <= {sum_w[0], lo_q[B_W-1:1]};
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  assign product_o     = {hi_q, lo_q};
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

/* rtl/spwm_div45.sv */
// ----------------------------------------------------------------------------
// spwm_div45
// restoring divider by the amplitude constant, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spwm_div45 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [spwm_pkg::AMP_DIV_W-1:0]    dividend_i,
  output logic [spwm_pkg::AMP_DIV_W-1:0]    quotient_o,
  output spwm_pkg::unit_status_t            status_o
);
  import spwm_pkg::*;

  localparam int unsigned CW    = $clog2(AMP_DIV_W + 1);
  localparam int unsigned REM_W = $clog2(AMP_DIVISOR);

  logic [AMP_DIV_W-1:0] xq_q;
  logic [REM_W-1:0]     rem_q;
  logic [CW-1:0]        cnt_q;
  logic                 done_q;
  logic [REM_W:0]       trial_w;
  logic                 ge_w;

  // dividend bits leave at the top, quotient bits enter at the bottom
  assign trial_w = {rem_q, xq_q[AMP_DIV_W-1]};
  assign ge_w    = (trial_w >= (REM_W + 1)'(AMP_DIVISOR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xq_q   <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        xq_q  <= dividend_i;
        rem_q <= '0;
        cnt_q <= CW'(AMP_DIV_W);
      end else if (cnt_q != '0) begin
        xq_q   <= {xq_q[AMP_DIV_W-2:0], ge_w};
        rem_q  <= ge_w ? REM_W'(trial_w - (REM_W + 1)'(AMP_DIVISOR)) : trial_w[REM_W-1:0];
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  assign quotient_o    = xq_q;
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

/* rtl/three_phase_sync_async_spwm.sv */
// ----------------------------------------------------------------------------
// three_phase_sync_async_spwm
// three-phase sine/triangle pwm with asynchronous and synchronous carrier
// ----------------------------------------------------------------------------
// One input beat is one pwm tick and yields exactly one result beat. All
// arithmetic of a tick with the inverter running goes through one bit-serial
// 17-bit multiplier, and a tick needs 19 products (speed gain, phase step,
// carrier frequency, carrier phase, then for each of the three phases four
// sine polynomial terms and the amplitude product), then a hand-off to the
// output register. The divide for the amplitude runs in parallel with the
// phase step product. A tick that does not run (disabled, or neither in power
// notch nor above the minimum speed) returns all zeros while clearing the w
// sine phase. A new tick is taken as soon as the sequencer is back in idle,
// even while the previous result still waits at the output.
// Configuration writes are always taken, but only take effect safely while no
// tick is in flight. SINE_TABLE_DEPTH must be a power of two.
module three_phase_sync_async_spwm #(
  parameter int unsigned PHASE_BITS       = 32,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  spwm_pkg::cfg_reg_e              cfg_index_i,
  input  logic [spwm_pkg::STEP_W-1:0]     cfg_data_i,
  // tick input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [spwm_pkg::SPEED_W-1:0]    vehicle_speed_i,
  input  logic                            power_notch_i,
  input  logic                            inverter_enable_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            gate_u_o,
  output logic                            gate_v_o,
  output logic                            gate_w_o,
  output logic [spwm_pkg::MODE_W-1:0]     pulse_mode_o,
  output logic [spwm_pkg::FREQ_W-1:0]     motor_freq_o,
  output logic [spwm_pkg::CFREQ_W-1:0]    carrier_freq_o,
  output logic [spwm_pkg::AMP_W-1:0]      amplitude_o
);
  import spwm_pkg::*;

  // multiplicand width covers both the phase and the phase step register
  localparam int unsigned AW = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
  localparam int unsigned PW = AW + MUL_B_W;
  localparam int unsigned LD = $clog2(SINE_TABLE_DEPTH);

  // one third and two thirds of a cycle, truncated
  localparam logic [63:0] THIRD_64     = (64'd1 << PHASE_BITS) / 64'd3;
  localparam logic [63:0] TWO_THIRD_64 = (64'd2 << PHASE_BITS) / 64'd3;
  localparam logic [PHASE_BITS-1:0] PH_THIRD     = THIRD_64[PHASE_BITS-1:0];
  localparam logic [PHASE_BITS-1:0] PH_TWO_THIRD = TWO_THIRD_64[PHASE_BITS-1:0];

  typedef enum logic [3:0] {
    S_IDLE,   // wait for a tick
    S_FS,     // speed * gain
    S_WINC,   // motor freq * phase step, amplitude divide alongside
    S_FC,     // motor freq * mode
    S_CAR,    // carrier phase product
    S_SZ2,    // z * z
    S_SP1,    // z2 * c0
    S_SP2,    // z2 * p1
    S_SS,     // z * p2
    S_GATE,   // amplitude * |sine|, then compare
    S_FIN     // hand result to the output register
  } state_e;

  typedef enum logic [1:0] {
    SEL_U = 2'd0,
    SEL_V = 2'd1,
    SEL_W = 2'd2
  } phase_sel_e;

  // configuration registers
  logic [STEP_W-1:0]  step_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [SPEED_W-1:0] min_speed_q;
  logic [CFREQ_W-1:0] afreq_q;

  // sequencer and working registers
  state_e                state_q;
  phase_sel_e            sel_q;
  logic                  run_q;
  logic [PHASE_BITS-1:0] w_q;
  logic [PHASE_BITS-1:0] car_q;
  logic [FREQ_W-1:0]     fs_q;
  logic [MODE_W-1:0]     mode_q;
  logic [CFREQ_W-1:0]    fc_q;
  logic [AMP_W-1:0]      amp_q;
  logic [2:0]            gate_q;
  logic [14:0]           z_q;
  logic [14:0]           z2_q;
  logic                  neg_q;

  // arithmetic unit operands
  logic                  mul_start_q;
  logic [AW-1:0]         mul_a_q;
  logic [MUL_B_W-1:0]    mul_b_q;
  logic                  div_start_q;
  logic [AMP_DIV_W-1:0]  div_x_q;

  // output register
  logic                  out_valid_q;
  logic [2:0]            out_gate_q;
  logic [MODE_W-1:0]     out_mode_q;
  logic [FREQ_W-1:0]     out_fs_q;
  logic [CFREQ_W-1:0]    out_fc_q;
  logic [AMP_W-1:0]      out_amp_q;

  logic [PW-1:0]         mul_prod;
  unit_status_t          mul_st;
  logic [AMP_DIV_W-1:0]  div_q;
  unit_status_t          div_st;

  // --------------------------------------------------------------------------
  // configuration port, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= RST_PHASE_STEP;
      gain_q      <= RST_FREQ_GAIN;
      min_speed_q <= RST_MIN_SPEED;
      afreq_q     <= RST_ASYNC_FREQ;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PHASE_STEP: step_q      <= cfg_data_i;
        REG_FREQ_GAIN:  gain_q      <= cfg_data_i[GAIN_W-1:0];
        REG_MIN_SPEED:  min_speed_q <= cfg_data_i[SPEED_W-1:0];
        REG_ASYNC_FREQ: afreq_q     <= cfg_data_i[CFREQ_W-1:0];
        default:        step_q      <= step_q;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // shared serial units
  // --------------------------------------------------------------------------
  spwm_smul #(
    .A_W (AW),
    .B_W (MUL_B_W)
  ) u_smul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start_q),
    .a_i       (mul_a_q),
    .b_i       (mul_b_q),
    .product_o (mul_prod),
    .status_o  (mul_st)
  );

  spwm_div45 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_x_q),
    .quotient_o (div_q),
    .status_o   (div_st)
  );

  // --------------------------------------------------------------------------
  // product post-processing
  // --------------------------------------------------------------------------
  logic                  run_w;
  logic [FREQ_W-1:0]     fs_w;
  logic [PHASE_BITS-1:0] inc_w;
  logic [MODE_W-1:0]     mode_w;
  logic [MODE_W-1:0]     car_mult_w;
  logic [22:0]           fc_raw_w;
  logic [CFREQ_W-1:0]    fc_w;
  logic [20:0]           amp_sum_w;
  logic [AMP_W-1:0]      amp_w;
  logic [14:0]           prod_q14_w;
  logic [14:0]           p1_w;
  logic [14:0]           p2_w;
  logic [15:0]           s_raw_w;
  logic [14:0]           s_w;

  assign run_w = inverter_enable_i && (power_notch_i || (vehicle_speed_i > min_speed_q));

  // speed * gain is q8.8 * q4.12, back to q8.8 with saturation
  assign fs_w  = (mul_prod[31:28] != 4'd0) ? FREQ_MAX : mul_prod[27:12];
  // phase increments drop the q8 fraction of the frequency
  assign inc_w = mul_prod[PHASE_BITS+7:8];

  always_comb begin
    if (fs_q > THR_MODE_1) begin
      mode_w = MODE_1;
    end else if (fs_q > THR_MODE_3) begin
      mode_w = MODE_3;
    end else if (fs_q > THR_MODE_9) begin
      mode_w = MODE_9;
    end else if (fs_q > THR_MODE_15) begin
      mode_w = MODE_15;
    end else if (fs_q > THR_MODE_27) begin
      mode_w = MODE_27;
    end else if (fs_q > THR_MODE_45) begin
      mode_w = MODE_45;
    end else begin
      mode_w = MODE_ASYNC;
    end
  end

  // one-pulse mode runs the carrier at three times the u phase
  assign car_mult_w = (mode_q == MODE_1) ? MODE_1_CARRIER_MULT : mode_q;

  assign fc_raw_w = mul_prod[22:0];
  assign fc_w     = (fc_raw_w > 23'(CFREQ_MAX)) ? CFREQ_MAX : fc_raw_w[CFREQ_W-1:0];

  assign amp_sum_w = 21'(div_q) + 21'(AMP_OFFSET);
  assign amp_w     = (amp_sum_w > 21'(AMP_MAX)) ? AMP_W'(AMP_MAX) : amp_sum_w[AMP_W-1:0];

  // sine polynomial terms, every product is rescaled by 2^-14
  assign prod_q14_w = mul_prod[28:14];
  assign p1_w       = SIN_C1 - prod_q14_w;
  assign p2_w       = SIN_C2 - prod_q14_w;
  assign s_raw_w    = mul_prod[29:14];
  assign s_w        = (s_raw_w > 16'(Q14_ONE)) ? Q14_ONE : s_raw_w[14:0];

  // --------------------------------------------------------------------------
  // phase selection and quarter-wave folding
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] pu_w;
  logic [PHASE_BITS-1:0] pv_w;
  phase_sel_e            sel_w;
  logic [PHASE_BITS-1:0] ph_w;
  logic [LD-1:0]         idx_w;
  logic [15:0]           u_w;
  logic [13:0]           zraw_w;
  logic [14:0]           z_w;
  logic                  neg_w;

  assign pv_w = w_q + PH_THIRD;
  assign pu_w = w_q + PH_TWO_THIRD;

  // the gate state already looks at the next phase to start its sine
  assign sel_w = (state_q == S_GATE) ? phase_sel_e'(sel_q + 2'd1) : sel_q;

  always_comb begin
    case (sel_w)
      SEL_U:   ph_w = pu_w;
      SEL_V:   ph_w = pv_w;
      default: ph_w = w_q;
    endcase
  end

  // phase quantized to the table depth, then spread over 16 bits
  assign idx_w  = ph_w[PHASE_BITS-1 -: LD];
  assign u_w    = 16'(idx_w) << (16 - LD);
  assign zraw_w = u_w[13:0];
  assign z_w    = u_w[14] ? (Q14_ONE - {1'b0, zraw_w}) : {1'b0, zraw_w};
  assign neg_w  = u_w[15];

  // --------------------------------------------------------------------------
  // triangle carrier and gate compare
  // --------------------------------------------------------------------------
  logic [15:0]        tri_p_w;
  logic signed [17:0] tri_w;
  logic [29:0]        m_w;
  logic signed [31:0] lhs_w;
  logic signed [31:0] rhs_w;
  logic               gate_w;

  assign tri_p_w = car_q[PHASE_BITS-1 -: 16];

  always_comb begin
    if (tri_p_w < TRI_Q1) begin
      tri_w = -$signed({2'b00, tri_p_w});
    end else if (tri_p_w < TRI_Q3) begin
      tri_w = $signed({2'b00, tri_p_w}) - 18'sd32768;
    end else begin
      tri_w = 18'sd65536 - $signed({2'b00, tri_p_w});
    end
  end

  // amplitude * sine in q28 against triangle scaled to q28
  assign m_w    = mul_prod[29:0];
  assign lhs_w  = neg_q ? -$signed({2'b00, m_w}) : $signed({2'b00, m_w});
  assign rhs_w  = $signed({tri_w[17], tri_w[16:0], 14'd0});
  assign gate_w = (lhs_w >= rhs_w);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= SEL_U;
      run_q       <= 1'b0;
      w_q         <= '0;
      car_q       <= '0;
      fs_q        <= '0;
      mode_q      <= MODE_ASYNC;
      fc_q        <= '0;
      amp_q       <= '0;
      gate_q      <= '0;
      z_q         <= '0;
      z2_q        <= '0;
      neg_q       <= 1'b0;
      mul_start_q <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_start_q <= 1'b0;
      div_x_q     <= '0;
      out_valid_q <= 1'b0;
      out_gate_q  <= '0;
      out_mode_q  <= MODE_ASYNC;
      out_fs_q    <= '0;
      out_fc_q    <= '0;
      out_amp_q   <= '0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sel_q <= SEL_U;
            run_q <= run_w;
            if (run_w) begin
              mul_a_q     <= AW'(gain_q);
              mul_b_q     <= MUL_B_W'(vehicle_speed_i);
              mul_start_q <= 1'b1;
              state_q     <= S_FS;
            end else begin
              // stopped tick: zero result, w phase restarts, carrier holds
              w_q     <= '0;
              fs_q    <= '0;
              mode_q  <= MODE_ASYNC;
              fc_q    <= '0;
              amp_q   <= '0;
              gate_q  <= '0;
              state_q <= S_FIN;
            end
          end
        end

        S_FS: begin
          if (mul_st.done) begin
            fs_q        <= fs_w;
            mul_a_q     <= AW'(step_q);
            mul_b_q     <= MUL_B_W'(fs_w);
            mul_start_q <= 1'b1;
            div_x_q     <= {fs_w, 4'd0};
            div_start_q <= 1'b1;
            state_q     <= S_WINC;
          end
        end

        S_WINC: begin
          if (mul_st.done) begin
            w_q         <= w_q + inc_w;
            mode_q      <= mode_w;
            mul_a_q     <= AW'(fs_q);
            mul_b_q     <= MUL_B_W'(mode_w);
            mul_start_q <= 1'b1;
            state_q     <= S_FC;
          end
        end

        S_FC: begin
          if (mul_st.done) begin
            amp_q <= amp_w;
            if (mode_q == MODE_ASYNC) begin
              fc_q    <= afreq_q;
              mul_a_q <= AW'(step_q);
              mul_b_q <= MUL_B_W'(afreq_q);
            end else begin
              fc_q    <= fc_w;
              mul_a_q <= AW'(pu_w);
              mul_b_q <= MUL_B_W'(car_mult_w);
            end
            mul_start_q <= 1'b1;
            state_q     <= S_CAR;
          end
        end

        S_CAR: begin
          if (mul_st.done) begin
            if (mode_q == MODE_ASYNC) begin
              car_q <= car_q + inc_w;
            end else begin
              car_q <= mul_prod[PHASE_BITS-1:0];
            end
            z_q         <= z_w;
            neg_q       <= neg_w;
            mul_a_q     <= AW'(z_w);
            mul_b_q     <= MUL_B_W'(z_w);
            mul_start_q <= 1'b1;
            state_q     <= S_SZ2;
          end
        end

        S_SZ2: begin
          if (mul_st.done) begin
            z2_q        <= prod_q14_w;
            mul_a_q     <= AW'(prod_q14_w);
            mul_b_q     <= MUL_B_W'(SIN_C0);
            mul_start_q <= 1'b1;
            state_q     <= S_SP1;
          end
        end

        S_SP1: begin
          if (mul_st.done) begin
            mul_a_q     <= AW'(z2_q);
            mul_b_q     <= MUL_B_W'(p1_w);
            mul_start_q <= 1'b1;
            state_q     <= S_SP2;
          end
        end

        S_SP2: begin
          if (mul_st.done) begin
            mul_a_q     <= AW'(z_q);
            mul_b_q     <= MUL_B_W'(p2_w);
            mul_start_q <= 1'b1;
            state_q     <= S_SS;
          end
        end

        S_SS: begin
          if (mul_st.done) begin
            mul_a_q     <= AW'(amp_q);
            mul_b_q     <= MUL_B_W'(s_w);
            mul_start_q <= 1'b1;
            state_q     <= S_GATE;
          end
        end

        S_GATE: begin
          if (mul_st.done) begin
            gate_q[sel_q] <= gate_w;
            if (sel_q == SEL_W) begin
              state_q <= S_FIN;
            end else begin
              // next phase starts its sine right away
              sel_q       <= sel_w;
              z_q         <= z_w;
              neg_q       <= neg_w;
              mul_a_q     <= AW'(z_w);
              mul_b_q     <= MUL_B_W'(z_w);
              mul_start_q <= 1'b1;
              state_q     <= S_SZ2;
            end
          end
        end

        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_gate_q  <= gate_q;
            out_mode_q  <= mode_q;
            out_fs_q    <= fs_q;
            out_fc_q    <= fc_q;
            out_amp_q   <= amp_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign gate_u_o       = out_gate_q[SEL_U];
  assign gate_v_o       = out_gate_q[SEL_V];
  assign gate_w_o       = out_gate_q[SEL_W];
  assign pulse_mode_o   = out_mode_q;
  assign motor_freq_o   = out_fs_q;
  assign carrier_freq_o = out_fc_q;
  assign amplitude_o    = out_amp_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // the multiplier is never restarted while a product is still being formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> !mul_st.busy)
    else $error("multiplier restarted while busy");

  // the amplitude quotient is ready when the mode product completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FC && mul_st.done) |-> !div_st.busy)
    else $error("amplitude divide still busy when consumed");

  // a stopped tick leaves the w phase cleared at hand-off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !run_q) |-> (w_q == '0 && gate_q == 3'b000))
    else $error("stopped tick did not clear phase and gates");

  // an accepted beat always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_FS || state_q == S_FIN))
    else $error("accepted beat did not start the sequencer");

endmodule

/* tb/sv/spwm_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwm_tb_pkg
// tick-level predictor and result checker for the three-phase spwm block
// ----------------------------------------------------------------------------
package spwm_tb_pkg;
  import spwm_pkg::*;

  // one result beat, field order matches the concatenation in the monitor
  typedef struct packed {
    logic                gate_u;
    logic                gate_v;
    logic                gate_w;
    logic [MODE_W-1:0]   mode;
    logic [FREQ_W-1:0]   freq;
    logic [CFREQ_W-1:0]  cfreq;
    logic [AMP_W-1:0]    amp;
  } pwm_beat_t;

  localparam int unsigned TABLE_DEPTH     = 1024;
  localparam logic [31:0] THIRD_TURN      = 32'd1431655765;
  localparam logic [31:0] TWO_THIRDS_TURN = 32'd2863311530;
  localparam int unsigned ONE_PULSE_MULT  = 3;
  localparam int unsigned MAX_PRINTED     = 100;

  class spwm_tick_check;
    bit [31:0] step;
    bit [15:0] gain;
    bit [15:0] min_speed;
    bit [16:0] async_freq;
    bit [31:0] w_phase;
    bit [31:0] carrier_ph;
    pwm_beat_t expected_beats[$];
    int unsigned mismatches;
    int unsigned beats_seen;

    function new();
      step       = 32'd42950;
      gain       = 16'd13357;
      min_speed  = 16'd128;
      async_freq = 17'd51200;
      w_phase    = '0;
      carrier_ph = '0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        REG_PHASE_STEP: step       = data;
        REG_FREQ_GAIN:  gain       = data[15:0];
        REG_MIN_SPEED:  min_speed  = data[15:0];
        REG_ASYNC_FREQ: async_freq = data[16:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // quarter-wave odd polynomial on a quantized phase, q14
    function longint sine_q14(bit [31:0] ph);
      longint unsigned idx, u, z, z2, p, s;
      bit [1:0] quad;
      idx  = (64'(ph) * TABLE_DEPTH) >> 32;
      u    = (idx << 16) / TABLE_DEPTH;
      quad = 2'(u >> 14);
      z    = u & 64'h3FFF;
      if (quad[0]) z = 16384 - z;
      z2 = (z * z) >> 14;
      p  = 10583 - ((z2 * 1306) >> 14);
      p  = 25736 - ((z2 * p) >> 14);
      s  = (z * p) >> 14;
      if (s > 16384) s = 16384;
      return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function longint triangle_q14(bit [31:0] ph);
      longint p;
      p = ph[31:16];
      if (p < 16384) return -p;
      if (p < 49152) return p - 32768;
      return 65536 - p;
    endfunction

    function bit gate_level(longint unsigned amp, bit [31:0] ph, longint lvl);
      return (longint'(amp) * sine_q14(ph)) >= lvl * 16384;
    endfunction

    // advance the phase state by one tick and queue what it should produce
    function void take_tick(logic [15:0] speed, logic notch, logic en);
      pwm_beat_t b;
      longint unsigned fs, amp, fc, mult;
      bit [31:0] pu, pv;
      logic [MODE_W-1:0] mode;
      longint lvl;
      b = '0;
      if (!(en && (notch || speed > min_speed))) begin
        w_phase = '0;
        expected_beats.push_back(b);
        return;
      end
      fs = (64'(speed) * 64'(gain)) >> 12;
      if (fs > 65535) fs = 65535;
      w_phase = w_phase + 32'((fs * 64'(step)) >> 8);
      pv = w_phase + THIRD_TURN;
      pu = w_phase + TWO_THIRDS_TURN;
      amp = (fs * 16) / 45 + 1638;
      if (amp > 32767) amp = 32767;
      // thresholds 44.3, 38.0, 25.0, 13.7, 7.0, 5.4 hz, strictly above
      if (fs * 10 > 443 * 256)      mode = MODE_1;
      else if (fs * 10 > 380 * 256) mode = MODE_3;
      else if (fs * 10 > 250 * 256) mode = MODE_9;
      else if (fs * 10 > 137 * 256) mode = MODE_15;
      else if (fs * 10 > 70 * 256)  mode = MODE_27;
      else if (fs * 10 > 54 * 256)  mode = MODE_45;
      else                          mode = MODE_ASYNC;
      if (mode == MODE_ASYNC) begin
        fc = async_freq;
        carrier_ph = carrier_ph + 32'((64'(async_freq) * 64'(step)) >> 8);
      end else begin
        fc = fs * mode;
        if (fc > 131071) fc = 131071;
        mult = (mode == MODE_1) ? ONE_PULSE_MULT : mode;
        carrier_ph = 32'(64'(pu) * mult);
      end
      lvl = triangle_q14(carrier_ph);
      b.gate_u = gate_level(amp, pu, lvl);
      b.gate_v = gate_level(amp, pv, lvl);
      b.gate_w = gate_level(amp, w_phase, lvl);
      b.mode   = mode;
      b.freq   = fs[15:0];
      b.cfreq  = fc[16:0];
      b.amp    = amp[14:0];
      expected_beats.push_back(b);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    task match_result(pwm_beat_t got);
      pwm_beat_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        flag_mismatch($sformatf("beat %0d arrived with no tick pending", beats_seen));
        return;
      end
      want = expected_beats.pop_front();
      if (got.gate_u !== want.gate_u)
        flag_mismatch($sformatf("beat %0d gate_u %b want %b", beats_seen, got.gate_u,
                                want.gate_u));
      if (got.gate_v !== want.gate_v)
        flag_mismatch($sformatf("beat %0d gate_v %b want %b", beats_seen, got.gate_v,
                                want.gate_v));
      if (got.gate_w !== want.gate_w)
        flag_mismatch($sformatf("beat %0d gate_w %b want %b", beats_seen, got.gate_w,
                                want.gate_w));
      if (got.mode !== want.mode)
        flag_mismatch($sformatf("beat %0d pulse_mode %0d want %0d", beats_seen, got.mode,
                                want.mode));
      if (got.freq !== want.freq)
        flag_mismatch($sformatf("beat %0d motor_freq %0d want %0d", beats_seen, got.freq,
                                want.freq));
      if (got.cfreq !== want.cfreq)
        flag_mismatch($sformatf("beat %0d carrier_freq %0d want %0d", beats_seen,
                                got.cfreq, want.cfreq));
      if (got.amp !== want.amp)
        flag_mismatch($sformatf("beat %0d amplitude %0d want %0d", beats_seen, got.amp,
                                want.amp));
    endtask
  endclass

endpackage

/* tb/sv/tb_three_phase_sync_async_spwm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_phase_sync_async_spwm
// self-checking bench: drives speed/notch/enable ticks through the spwm block
// under several register settings and flow-control patterns, predicts every
// gate level, pulse mode, frequency and amplitude, and checks each beat
// ----------------------------------------------------------------------------
module tb_three_phase_sync_async_spwm;
  import spwm_pkg::*;
  import spwm_tb_pkg::*;

  // watchdog silence limit, well above the length of a running tick
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned TAIL_CYCLES     = 400;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned TICKS_PER_PHASE = 212;
  // highest motor_freq (q8.8) still below each pulse mode change
  localparam int unsigned MODE_EDGE [6] = '{11340, 9728, 6400, 3507, 1792, 1382};

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_e             cfg_index = REG_PHASE_STEP;
  logic [STEP_W-1:0]    cfg_data  = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SPEED_W-1:0]   speed  = '0;
  logic                 notch  = 1'b0;
  logic                 enable = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 gate_u, gate_v, gate_w;
  logic [MODE_W-1:0]    pulse_mode;
  logic [FREQ_W-1:0]    motor_freq;
  logic [CFREQ_W-1:0]   carrier_freq;
  logic [AMP_W-1:0]     amplitude;

  // flow-control knobs, changed only between phases
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet          = 0;

  spwm_tick_check sb;
  pwm_beat_t      seen;

  three_phase_sync_async_spwm dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .vehicle_speed_i   (speed),
    .power_notch_i     (notch),
    .inverter_enable_i (enable),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .gate_u_o          (gate_u),
    .gate_v_o          (gate_v),
    .gate_w_o          (gate_w),
    .pulse_mode_o      (pulse_mode),
    .motor_freq_o      (motor_freq),
    .carrier_freq_o    (carrier_freq),
    .amplitude_o       (amplitude)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // result monitor: every accepted beat goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = {gate_u, gate_v, gate_w, pulse_mode, motor_freq, carrier_freq, amplitude};
      sb.match_result(seen);
    end
  end

  // watchdog: any accepted beat on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("tb_three_phase_sync_async_spwm NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // smallest speed whose motor frequency reaches target under the current gain
  function automatic logic [SPEED_W-1:0] speed_for_freq(longint unsigned target);
    longint unsigned s;
    if (sb.gain == 0) return 16'($urandom());
    s = (target * 4096 + sb.gain - 1) / sb.gain;
    if (s > 65535) s = 65535;
    return 16'(s);
  endfunction

  // valid stays high across back-to-back writes, lowered by the caller
  task automatic write_reg(cfg_reg_e idx, logic [STEP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic send_tick(logic [SPEED_W-1:0] spd, logic nt, logic en);
    // random sender gaps; valid is only touched once per edge
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    speed    <= spd;
    notch    <= nt;
    enable   <= en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_tick(spd, nt, en);
  endtask

  // stop sending and let every outstanding tick come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic random_tick();
    logic [SPEED_W-1:0] spd;
    case ($urandom_range(0, 9))
      0, 1, 2:    spd = 16'($urandom());
      3, 4, 5, 6: spd = speed_for_freq($urandom_range(0, 12000));
      // straddle a pulse mode change
      7, 8:       spd = speed_for_freq(MODE_EDGE[$urandom_range(0, 5)] + 1)
                        - 16'($urandom_range(0, 1));
      // straddle the coasting threshold
      default:    spd = sb.min_speed + 16'($urandom_range(0, 2)) - 16'd1;
    endcase
    send_tick(spd, 1'($urandom_range(0, 99) < 60), 1'($urandom_range(0, 99) < 85));
  endtask

  // register set per phase; upper data bits are junk the block must drop
  task automatic load_settings(int ph);
    logic [31:0] step_v;
    logic [15:0] gain_v, min_v;
    logic [16:0] async_v;
    case (ph)
      1: begin
        step_v = 32'd1; gain_v = 16'hFFFF; min_v = 16'd0; async_v = 17'h1FFFF;
      end
      2: begin
        step_v = 32'hFFFF_FFFF; gain_v = 16'd0; min_v = 16'hFFFF; async_v = 17'd0;
      end
      5: begin
        step_v = 32'd42950; gain_v = 16'd13357; min_v = 16'd128; async_v = 17'd51200;
      end
      default: begin
        step_v  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1000, 200000);
        gain_v  = 16'($urandom_range(1, 65535));
        min_v   = 16'($urandom_range(0, 4000));
        async_v = 17'($urandom_range(0, 131071));
      end
    endcase
    write_reg(REG_PHASE_STEP, step_v);
    write_reg(REG_FREQ_GAIN, {16'($urandom()), gain_v});
    write_reg(REG_MIN_SPEED, {16'($urandom()), min_v});
    write_reg(REG_ASYNC_FREQ, {15'($urandom()), async_v});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SPEED_W-1:0] above_spd;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at reset settings, no flow-control gaps
    send_tick(16'd0, 1'b1, 1'b1);      // standstill in power notch still runs
    send_tick(16'hFFFF, 1'b1, 1'b1);   // top speed, motor_freq saturates
    send_tick(16'hFFFF, 1'b1, 1'b0);   // disabled forces all zero
    send_tick(16'hFFFF, 1'b0, 1'b0);
    send_tick(16'd128, 1'b0, 1'b1);    // coasting at exactly min speed: idle
    send_tick(16'd129, 1'b0, 1'b1);    // one lsb above: runs from a cleared w phase
    send_tick(16'd0, 1'b0, 1'b1);      // idle again, w phase clears
    // each pulse mode from both sides of its threshold, async included
    foreach (MODE_EDGE[k]) begin
      above_spd = speed_for_freq(MODE_EDGE[k] + 1);
      send_tick(above_spd - 16'd1, 1'b1, 1'b1);
      send_tick(above_spd, 1'b1, 1'b1);
    end
    send_tick(16'h5555, 1'b1, 1'b1);
    send_tick(16'hAAAA, 1'b0, 1'b1);
    drain();

    // random phases, each with its own registers and flow-control pattern
    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph % 4)
        1:       begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 47; end
        3:       begin src_idle_pct = 6;  sink_stall_pct = 6;  end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      load_settings(ph);
      repeat (TICKS_PER_PHASE) random_tick();
      drain();
    end

    // give any stray beat time to show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_three_phase_sync_async_spwm OK");
    end else begin
      $display("tb_three_phase_sync_async_spwm NOT OK");
    end
    $finish;
  end

endmodule

/* three_phase_sync_async_spwm.f */
rtl/spwm_pkg.sv
rtl/spwm_smul.sv
rtl/spwm_div45.sv
rtl/three_phase_sync_async_spwm.sv
tb/sv/spwm_tb_pkg.sv
tb/sv/tb_three_phase_sync_async_spwm.sv
